// File: hw/rtl/ssd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_pkg
// Shared types, widths and helper functions for the seven-segment scanner.
// ----------------------------------------------------------------------------
package ssd_pkg;

    // Word kinds
    typedef enum logic {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } t_op;

    localparam int NUMBER_W   = 14;
    localparam int SEG_W      = 7;
    localparam int SEL_W      = 4;
    // 14-bit binary needs at most five decimal digits
    localparam int BCD_DIGITS = 5;
    localparam int BCD_W      = BCD_DIGITS * 4;
    localparam int QUEUE_DEPTH = 2;

    typedef logic [BCD_W-1:0] t_bcd;
    typedef logic [3:0]       t_digit;
    typedef logic [SEG_W-1:0] t_seg;

    // Largest value shown by n digits, 10^n - 1 (elaboration only)
    function automatic int max_value(input int n);
        int m;
        m = 1;
        for (int k = 0; k < n; k++) begin
            m = m * 10;
        end
        return m - 1;
    endfunction

    // One shift-and-add-3 step of binary to BCD conversion
    function automatic t_bcd bcd_step(input t_bcd b, input logic bit_in);
        t_bcd a;
        a = b;
        for (int k = 0; k < BCD_DIGITS; k++) begin
            if (a[k*4 +: 4] >= 4'd5) begin
                a[k*4 +: 4] = a[k*4 +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], bit_in};
    endfunction

    // Segment pattern of one decimal digit
    function automatic t_seg seg_of(input t_digit d);
        t_seg s;
        unique case (d)
            4'd0:    s = 7'h7E;
            4'd1:    s = 7'h30;
            4'd2:    s = 7'h6D;
            4'd3:    s = 7'h79;
            4'd4:    s = 7'h33;
            4'd5:    s = 7'h5B;
            4'd6:    s = 7'h5F;
            4'd7:    s = 7'h70;
            4'd8:    s = 7'h7F;
            4'd9:    s = 7'h7B;
            default: s = 7'h00;
        endcase
        return s;
    endfunction

endpackage

// File: hw/rtl/ssd_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_front
// Accepts words, saturates loads, converts them to decimal in two halves and
// turns the digits into blanked segment patterns. Three pipeline stages.
// ----------------------------------------------------------------------------
module ssd_front #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_op,
    input  logic [ssd_pkg::NUMBER_W-1:0]        i_number,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_op,
    output logic [DIGIT_COUNT*ssd_pkg::SEG_W-1:0] o_patterns
);

    localparam int LIM   = ssd_pkg::max_value(DIGIT_COUNT);
    localparam int HALF  = ssd_pkg::NUMBER_W / 2;
    localparam int PAT_W = DIGIT_COUNT * ssd_pkg::SEG_W;

    logic                         r_v1, r_v2, r_v3;
    logic                         r_op1, r_op2, r_op3;
    logic [ssd_pkg::NUMBER_W-1:0] r_n1;
    ssd_pkg::t_bcd                r_bcd2;
    logic [HALF-1:0]              r_low2;
    logic [PAT_W-1:0]             r_pat3;

    logic                         rdy1, rdy2, rdy3;
    logic [ssd_pkg::NUMBER_W-1:0] sat_n;
    ssd_pkg::t_bcd                n_bcd2;
    logic [PAT_W-1:0]             n_pat3;

    // Stage enables: a stage loads when it is empty or draining
    assign rdy3    = !r_v3 || i_ready;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // Saturate to the largest displayable value
    assign sat_n = ({18'd0, i_number} > 32'(LIM)) ? ssd_pkg::NUMBER_W'(LIM) : i_number;

    // Upper half of the conversion
    always_comb begin
        n_bcd2 = '0;
        for (int k = 0; k < ssd_pkg::NUMBER_W - HALF; k++) begin
            n_bcd2 = ssd_pkg::bcd_step(n_bcd2, r_n1[ssd_pkg::NUMBER_W-1-k]);
        end
    end

    // Lower half, digit lookup and leading-zero blanking
    always_comb begin
        ssd_pkg::t_bcd  bcd;
        ssd_pkg::t_digit d;
        logic           seen;
        int             idx;
        bcd    = r_bcd2;
        seen   = 1'b0;
        n_pat3 = '0;
        for (int k = 0; k < HALF; k++) begin
            bcd = ssd_pkg::bcd_step(bcd, r_low2[HALF-1-k]);
        end
        for (int p = 0; p < DIGIT_COUNT; p++) begin
            idx = DIGIT_COUNT - 1 - p;
            d   = '0;
            if (idx < ssd_pkg::BCD_DIGITS) begin
                d = bcd[idx*4 +: 4];
            end
            if (d != 4'd0) begin
                seen = 1'b1;
            end
            if (seen || (p == DIGIT_COUNT - 1)) begin
                n_pat3[p*ssd_pkg::SEG_W +: ssd_pkg::SEG_W] = ssd_pkg::seg_of(d);
            end
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (rdy1) r_v1 <= i_valid;
            if (rdy2) r_v2 <= r_v1;
            if (rdy3) r_v3 <= r_v2;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (rdy1) begin
            r_op1 <= i_op;
            r_n1  <= sat_n;
        end
        if (rdy2) begin
            r_op2  <= r_op1;
            r_bcd2 <= n_bcd2;
            r_low2 <= r_n1[HALF-1:0];
        end
        if (rdy3) begin
            r_op3  <= r_op2;
            r_pat3 <= n_pat3;
        end
    end

    assign o_valid    = r_v3;
    assign o_op       = r_op3;
    assign o_patterns = r_pat3;

endmodule

// File: hw/rtl/ssd_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_queue
// Two-entry word queue between the front and back parts.
// ----------------------------------------------------------------------------
module ssd_queue #(
    parameter int WIDTH = 29
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [ssd_pkg::QUEUE_DEPTH];
    logic             r_wptr, r_rptr;
    logic [1:0]       r_count;
    logic             push, pop;

    assign o_ready = (r_count != 2'(ssd_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != 2'd0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_data  = r_mem[r_rptr];

    // Storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= i_data;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) r_wptr <= ~r_wptr;
            if (pop)  r_rptr <= ~r_rptr;
            r_count <= r_count + 2'(push) - 2'(pop);
        end
    end

endmodule

// File: hw/rtl/ssd_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssd_back
// Holds the digit patterns and the scan position; stores loads and answers
// ticks through a registered output.
// ----------------------------------------------------------------------------
module ssd_back #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_op,
    input  logic [DIGIT_COUNT*ssd_pkg::SEG_W-1:0] i_patterns,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [ssd_pkg::SEG_W-1:0]             o_segments,
    output logic [ssd_pkg::SEL_W-1:0]             o_digit_select
);

    localparam int SCAN_W = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
    localparam int PAT_W  = DIGIT_COUNT * ssd_pkg::SEG_W;

    logic [PAT_W-1:0]          r_pat;
    logic [SCAN_W-1:0]         r_scan;
    logic                      r_out_v;
    logic [ssd_pkg::SEG_W-1:0] r_seg;
    logic [ssd_pkg::SEL_W-1:0] r_sel;

    logic                      is_tick, out_free, pop_load, pop_tick;
    logic [SCAN_W-1:0]         n_scan;
    logic [ssd_pkg::SEL_W-1:0] n_sel;

    assign is_tick  = (ssd_pkg::t_op'(i_op) == ssd_pkg::OP_TICK);
    assign out_free = !r_out_v || i_ready;
    // Loads never wait on the output register
    assign o_ready  = !is_tick || out_free;
    assign pop_load = i_valid && !is_tick;
    assign pop_tick = i_valid && is_tick && out_free;

    // Next scan position, wraps at the last digit
    assign n_scan = (r_scan == SCAN_W'(DIGIT_COUNT - 1)) ? '0 : r_scan + 1'b1;

    // One-hot select; positions past the field width select nothing
    always_comb begin
        for (int b = 0; b < ssd_pkg::SEL_W; b++) begin
            n_sel[b] = (32'(r_scan) == b);
        end
    end

    // Pattern store and scan counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat  <= '0;
            r_scan <= '0;
        end else begin
            if (pop_load) r_pat  <= i_patterns;
            if (pop_tick) r_scan <= n_scan;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (out_free) begin
            r_out_v <= pop_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop_tick) begin
            r_seg <= r_pat[r_scan*ssd_pkg::SEG_W +: ssd_pkg::SEG_W];
            r_sel <= n_sel;
        end
    end

    assign o_valid        = r_out_v;
    assign o_segments     = r_seg;
    assign o_digit_select = r_sel;

    // Checks
    a_scan_only_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !pop_tick |=> $stable(r_scan))
        else $error("scan position moved without a tick");

    a_load_stored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_load |=> (r_pat == $past(i_patterns)))
        else $error("load word not stored");

    a_tick_shown: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop_tick |=> (r_out_v && $onehot0(r_sel)))
        else $error("tick word not presented");

endmodule

// File: hw/rtl/seven_segment_display_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// seven_segment_display_scanner_core
// Multiplexed seven-segment driver: load words set the shown number, tick
// words return one digit's segments and one-hot select.
// ----------------------------------------------------------------------------
// One word is accepted per cycle while o_ready is high, loads and ticks alike. A
// load runs through a three-stage conversion pipeline (saturate; upper half of
// binary-to-BCD; lower half with segment lookup and leading-zero blanking) and a
// two-entry queue before it reaches the pattern store; ticks follow the same
// path and come out of a registered output, so a tick result always sees every
// load accepted ahead of it. Loads give no result word.
module seven_segment_display_scanner_core #(
    parameter int DIGIT_COUNT = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_op,
    input  logic [ssd_pkg::NUMBER_W-1:0]      i_number,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [ssd_pkg::SEG_W-1:0]         o_segments,
    output logic [ssd_pkg::SEL_W-1:0]         o_digit_select
);

    localparam int PAT_W = DIGIT_COUNT * ssd_pkg::SEG_W;

    logic             f_valid, f_ready, f_op;
    logic [PAT_W-1:0] f_pat;
    logic             q_valid, q_ready;
    logic [PAT_W:0]   q_data;

    // Front: conversion pipeline
    ssd_front #(.DIGIT_COUNT(DIGIT_COUNT)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_op       (i_op),
        .i_number   (i_number),
        .o_valid    (f_valid),
        .i_ready    (f_ready),
        .o_op       (f_op),
        .o_patterns (f_pat)
    );

    // Queue between front and back
    ssd_queue #(.WIDTH(PAT_W + 1)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .o_ready (f_ready),
        .i_data  ({f_op, f_pat}),
        .o_valid (q_valid),
        .i_ready (q_ready),
        .o_data  (q_data)
    );

    // Back: pattern store and scan
    ssd_back #(.DIGIT_COUNT(DIGIT_COUNT)) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (q_valid),
        .o_ready        (q_ready),
        .i_op           (q_data[PAT_W]),
        .i_patterns     (q_data[PAT_W-1:0]),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_segments     (o_segments),
        .o_digit_select (o_digit_select)
    );

endmodule

// File: tb/tb_seven_segment_display_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_seven_segment_display_scanner_core
// Self-checking bench for the four-digit scanner: drives load and tick words,
// predicts each scan result from a local copy of the digit store and scan
// position, and checks every result word in order under varied idling and a
// long output hold-off.
// ----------------------------------------------------------------------------
module tb_seven_segment_display_scanner_core;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 200;
    localparam int REPORT_MAX   = 20;

    // Segment patterns of the decimal digits 0..9
    localparam logic [ssd_pkg::SEG_W-1:0] DIGIT_SEGS [0:9] = '{
        7'h7E, 7'h30, 7'h6D, 7'h79, 7'h33, 7'h5B, 7'h5F, 7'h70, 7'h7F, 7'h7B
    };

    typedef struct packed {
        logic [ssd_pkg::SEG_W-1:0] seg;
        logic [ssd_pkg::SEL_W-1:0] sel;
    } t_scan_word;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_ready;
    logic                         i_op;
    logic [ssd_pkg::NUMBER_W-1:0] i_number;
    logic                         o_valid;
    logic                         i_ready;
    logic [ssd_pkg::SEG_W-1:0]    o_segments;
    logic [ssd_pkg::SEL_W-1:0]    o_digit_select;

    // Local copy of the display state
    logic [ssd_pkg::SEG_W-1:0] shown_digits [0:3];
    logic [1:0]                scan_pos;
    t_scan_word                pending_scans [$];

    int tx_idle_pct;
    int rx_stall_pct;
    bit rx_hold_req;
    int rx_hold_left;
    int cycle_count;
    int mismatches;
    int loads_sent;
    int ticks_sent;
    int scans_checked;

    seven_segment_display_scanner_core #(
        .DIGIT_COUNT(4)
    ) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_op           (i_op),
        .i_number       (i_number),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_segments     (o_segments),
        .o_digit_select (o_digit_select)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Saturate, split into decimal digits, blank leading zeros
    function automatic void update_digits(input int unsigned value);
        int unsigned n;
        int unsigned scale;
        int unsigned d;
        bit          leading;
        n       = (value > 9999) ? 9999 : value;
        scale   = 1000;
        leading = 1'b1;
        for (int k = 0; k < 4; k++) begin
            d = (n / scale) % 10;
            if (d != 0) begin
                leading = 1'b0;
            end
            shown_digits[k] = (leading && k != 3) ? '0 : DIGIT_SEGS[d];
            scale = scale / 10;
        end
    endfunction

    // Pattern and select of the current scan digit; advances the scan
    function automatic t_scan_word next_scan();
        t_scan_word w;
        w.seg    = shown_digits[scan_pos];
        w.sel    = 4'b0001 << scan_pos;
        scan_pos = scan_pos + 2'd1;
        return w;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
            $display("MISMATCH cycle %0d: %s got 0x%0h want 0x%0h",
                     cycle_count, what, got, want);
        end
    endtask

    // Offer one word, hold it until accepted, then maybe go idle
    task automatic send_word(input ssd_pkg::t_op op,
                             input logic [ssd_pkg::NUMBER_W-1:0] number);
        i_valid  <= 1'b1;
        i_op     <= op;
        i_number <= number;
        @(posedge i_clk);
        while (!o_ready) begin
            @(posedge i_clk);
        end
        if (op == ssd_pkg::OP_LOAD) begin
            update_digits(32'(number));
            loads_sent++;
        end else begin
            pending_scans.push_back(next_scan());
            ticks_sent++;
        end
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            i_valid  <= 1'b0;
            i_op     <= 1'($urandom_range(1));
            i_number <= ssd_pkg::NUMBER_W'($urandom_range(16383));
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drain();
        while (pending_scans.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Mostly realistic values, with the saturating range and small numbers
    function automatic logic [ssd_pkg::NUMBER_W-1:0] pick_number();
        int unsigned specials [10] = '{0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000};
        unique case ($urandom_range(9))
            0, 1, 2, 3: return ssd_pkg::NUMBER_W'($urandom_range(16383));
            4, 5:       return ssd_pkg::NUMBER_W'($urandom_range(9999));
            6, 7:       return ssd_pkg::NUMBER_W'($urandom_range(99));
            8:          return ssd_pkg::NUMBER_W'(specials[$urandom_range(9)]);
            default:    return ssd_pkg::NUMBER_W'($urandom_range(16383, 10000));
        endcase
    endfunction

    task automatic tick_n(input int n);
        repeat (n) send_word(ssd_pkg::OP_TICK, ssd_pkg::NUMBER_W'($urandom_range(16383)));
    endtask

    // Store is blank after reset; the scan walks all four selects
    task automatic test_blank_after_reset();
        tick_n(4);
    endtask

    // Zero, the 14-bit maximum and the first saturating value
    task automatic test_extremes();
        send_word(ssd_pkg::OP_LOAD, 14'd0);
        tick_n(4);
        send_word(ssd_pkg::OP_LOAD, 14'h3FFF);
        tick_n(4);
        send_word(ssd_pkg::OP_LOAD, 14'd10000);
        tick_n(4);
    endtask

    // A load leaves the scan position where it was
    task automatic test_load_mid_scan();
        send_word(ssd_pkg::OP_LOAD, 14'd1009);
        tick_n(2);
        send_word(ssd_pkg::OP_LOAD, 14'd70);
        tick_n(2);
    endtask

    // Mostly load-then-full-scan sequences, some single random words
    task automatic test_random(input int count, input int tx_pct, input int rx_pct);
        int sent;
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 80) begin
                send_word(ssd_pkg::OP_LOAD, pick_number());
                tick_n(4);
                sent += 5;
            end else begin
                send_word(ssd_pkg::t_op'($urandom_range(1)), pick_number());
                sent++;
            end
        end
    endtask

    // Receiver holds off for a long stretch while words keep coming
    task automatic test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1'b1;
        repeat (8) begin
            send_word(ssd_pkg::OP_LOAD, pick_number());
            tick_n(4);
        end
    endtask

    // Receiver ready, with random stalls and the long hold-off
    always @(posedge i_clk) begin
        if (rx_hold_req) begin
            rx_hold_left = HOLD_CYCLES;
            rx_hold_req  = 1'b0;
        end
        if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Check each result word against the oldest expectation
    always @(posedge i_clk) begin : check_scans
        t_scan_word want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_scans.size() == 0) begin
                report_mismatch("unexpected result word, segments", int'(o_segments), 0);
            end else begin
                want = pending_scans.pop_front();
                if (o_segments !== want.seg) begin
                    report_mismatch("segments", int'(o_segments), int'(want.seg));
                end
                if (o_digit_select !== want.sel) begin
                    report_mismatch("digit_select", int'(o_digit_select), int'(want.sel));
                end
                scans_checked++;
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_scans.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_op         <= ssd_pkg::OP_LOAD;
        i_number     <= '0;
        i_ready      <= 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        rx_hold_req  = 1'b0;
        rx_hold_left = 0;
        cycle_count  = 0;
        mismatches   = 0;
        loads_sent   = 0;
        ticks_sent   = 0;
        scans_checked = 0;
        scan_pos     = '0;
        for (int k = 0; k < 4; k++) begin
            shown_digits[k] = '0;
        end
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_blank_after_reset();
        test_extremes();
        test_load_mid_scan();
        test_random(120, 0, 0);
        test_random(120, 60, 0);
        test_random(120, 0, 60);
        test_random(120, 11, 11);
        test_backpressure();
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        i_valid <= 1'b0;
        wait_drain();

        $display("Sent %0d loads and %0d ticks; %0d scan words checked, %0d mismatches",
                 loads_sent, ticks_sent, scans_checked, mismatches);
        $display("Covered blanking, saturation, mid-scan loads, idling and a long stall");
        if (mismatches == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
